// ===== rtl/ggba_pkg.sv =====
// Package for the gyro bias averager: register indexes, fixed field widths and
// the control word that the sequencer hands to the axis lanes.
// No dependencies.
`default_nettype none

package ggba_pkg;

  // Default width of the saturating sample counter
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned RATE_W  = 24;  // Q16.8 input rates
  localparam int unsigned BIAS_W  = 32;  // Q16.16 bias estimates
  localparam int unsigned CORR_W  = 33;  // Q17.16 corrected rates
  localparam int unsigned TOL_W   = 23;  // tolerance register
  localparam int unsigned LIMIT_W = 16;  // count limit register
  localparam int unsigned WIN_W   = 31;  // tolerance scaled to Q16.16
  localparam int unsigned CFG_W   = 23;  // configuration data width
  localparam int unsigned CNTO_W  = 16;  // reported count width

  // Configuration register indexes
  localparam logic [0:0] REG_TOLERANCE   = 1'b0;
  localparam logic [0:0] REG_COUNT_LIMIT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [TOL_W-1:0]   TOLERANCE_RST   = 23'd2560;
  localparam logic [LIMIT_W-1:0] COUNT_LIMIT_RST = 16'd10000;

  // Sequencer to lane control
  typedef struct packed {
    logic start;   // capture sample and count, form bias * count
    logic div_go;  // launch the serial divider
    logic commit;  // write back the new bias
    logic acc;     // the sample passed the window check
  } ggba_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gated_gyro_bias_averager_unit.sv =====
// Top level of the gated gyro bias averager: configuration registers, item
// sequencer, three axis lanes and the merge into the output word register.
// Depends on ggba_pkg and ggba_lane.
`default_nettype none

// Each input word is one three-axis gyro sample in signed Q16.8 deg/s; each
// output word carries the updated Q16.16 biases, the bias-corrected rates in
// Q17.16, the accept flag and the sample count. A sample is folded into the
// running mean when the count is zero or when all three deviations from the
// current bias lie strictly inside +/- tolerance; the count rises on every
// sample up to count_limit (and the counter's own maximum). The three axes
// run in parallel lanes, each with its own one-bit-per-cycle restoring
// divider. An item goes from acceptance to its result word as follows: the
// bias * count product is registered at acceptance, the sequencer then
// launches the dividers, they step through the COUNT_WIDTH + 34 bit
// numerator, the sequencer sees them finish and then writes back once the
// output register has room. One item is in work at a time; a finished word
// waits in the output register and the next sample is taken meanwhile.
// Configuration writes belong to idle periods only.

module gated_gyro_bias_averager_unit #(
  parameter int unsigned COUNT_WIDTH = ggba_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [0:0]                            cfg_index_i,
  input  wire logic [ggba_pkg::CFG_W-1:0]            cfg_data_i,
  // input words
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [ggba_pkg::RATE_W-1:0]    rate_x_i,
  input  wire logic signed [ggba_pkg::RATE_W-1:0]    rate_y_i,
  input  wire logic signed [ggba_pkg::RATE_W-1:0]    rate_z_i,
  // output words
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [ggba_pkg::BIAS_W-1:0]         bias_out_x_o,
  output logic signed [ggba_pkg::BIAS_W-1:0]         bias_out_y_o,
  output logic signed [ggba_pkg::BIAS_W-1:0]         bias_out_z_o,
  output logic signed [ggba_pkg::CORR_W-1:0]         corrected_x_o,
  output logic signed [ggba_pkg::CORR_W-1:0]         corrected_y_o,
  output logic signed [ggba_pkg::CORR_W-1:0]         corrected_z_o,
  output logic                                       accepted_o,
  output logic [ggba_pkg::CNTO_W-1:0]                count_out_o
);

  // Width that holds both the counter and the limit register for compares
  localparam int unsigned CXW = (COUNT_WIDTH > ggba_pkg::LIMIT_W) ?
                                COUNT_WIDTH : ggba_pkg::LIMIT_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // wait for a sample
    ST_MUL  = 4'b0010,  // product registered, launch the dividers
    ST_DIV  = 4'b0100,  // dividers stepping
    ST_DONE = 4'b1000   // wait for room in the output register
  } state_e;

  state_e state_q, state_d;

  logic [ggba_pkg::TOL_W-1:0]   tol_q;
  logic [ggba_pkg::LIMIT_W-1:0] limit_q;
  logic [COUNT_WIDTH-1:0]       count_q, count_d;
  logic                         acc_q;
  logic                         out_valid_q;

  logic [ggba_pkg::WIN_W-1:0]   win;
  logic                         in_take, out_take, commit, acc_now, count_inc;
  logic                         inside_x, inside_y, inside_z;
  logic                         done_x, done_y, done_z;
  logic signed [ggba_pkg::BIAS_W-1:0] bias_x, bias_y, bias_z;
  logic signed [ggba_pkg::CORR_W-1:0] corr_x, corr_y, corr_z;
  ggba_pkg::ggba_ctrl_t         ctrl;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= ggba_pkg::TOLERANCE_RST;
      limit_q <= ggba_pkg::COUNT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ggba_pkg::REG_TOLERANCE:   tol_q   <= cfg_data_i;
        ggba_pkg::REG_COUNT_LIMIT: limit_q <= cfg_data_i[ggba_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Tolerance scaled from Q16.8 to Q16.16
  assign win = {tol_q, 8'b0};

  // ---------------------------------------------------------------------
  // Handshakes and sequencer
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);
  assign out_take   = out_valid_q && !out_stall_i;

  // Merge the lane verdicts: the first sample always passes
  assign acc_now = (count_q == '0) || (inside_x && inside_y && inside_z);

  // Write back once the output register is free or being emptied
  assign commit = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // The lanes step in lock-step; advance once every divider has finished
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_take) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (done_x && done_y && done_z) state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.start  = in_take;
    ctrl.div_go = (state_q == ST_MUL);
    ctrl.commit = commit;
    ctrl.acc    = acc_q;
  end

  // Saturating count: stop at the limit and at the counter's own maximum
  assign count_inc = (CXW'(count_q) < CXW'(limit_q)) && (count_q != '1);
  assign count_d   = count_inc ? (count_q + COUNT_WIDTH'(1)) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        acc_q <= acc_now;
      end
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Axis lanes
  // ---------------------------------------------------------------------
  ggba_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (rate_x_i),
    .win_i       (win),
    .count_i     (count_q),
    .inside_o    (inside_x),
    .done_o      (done_x),
    .bias_o      (bias_x),
    .corrected_o (corr_x)
  );

  ggba_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (rate_y_i),
    .win_i       (win),
    .count_i     (count_q),
    .inside_o    (inside_y),
    .done_o      (done_y),
    .bias_o      (bias_y),
    .corrected_o (corr_y)
  );

  ggba_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (rate_z_i),
    .win_i       (win),
    .count_i     (count_q),
    .inside_o    (inside_z),
    .done_o      (done_z),
    .bias_o      (bias_z),
    .corrected_o (corr_z)
  );

  // ---------------------------------------------------------------------
  // Output word register: load on write back, hold while stalled
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (commit) begin
      bias_out_x_o  <= bias_x;
      bias_out_y_o  <= bias_y;
      bias_out_z_o  <= bias_z;
      corrected_x_o <= corr_x;
      corrected_y_o <= corr_y;
      corrected_z_o <= corr_z;
      accepted_o    <= acc_q;
      count_out_o   <= ggba_pkg::CNTO_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/ggba_div.sv =====
// Radix-2 restoring divider for a signed numerator and an unsigned non-zero
// divisor, one quotient bit per cycle, truncating toward zero.
// No package dependencies.
`default_nettype none

module ggba_div #(
  parameter int unsigned NUM_WIDTH = 50,
  parameter int unsigned DEN_WIDTH = 17
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [NUM_WIDTH-1:0] num_i,
  input  wire logic        [DEN_WIDTH-1:0] den_i,
  output logic                             done_o,
  output logic signed      [NUM_WIDTH-1:0] quot_o
);

  localparam int unsigned CTR_W = $clog2(NUM_WIDTH + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CTR_W-1:0]     ctr_q;
  logic [NUM_WIDTH-1:0] q_q, q_d;
  logic [DEN_WIDTH:0]   rem_q, rem_d;
  logic [DEN_WIDTH-1:0] den_q;
  logic                 neg_q;
  logic [NUM_WIDTH-1:0] num_abs;
  logic [DEN_WIDTH:0]   rem_sh;
  logic                 ge;

  assign num_abs = num_i[NUM_WIDTH-1] ? (~num_i + NUM_WIDTH'(1)) : num_i;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q[DEN_WIDTH-1:0], q_q[NUM_WIDTH-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    q_d    = {q_q[NUM_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ctr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ctr_q  <= CTR_W'(NUM_WIDTH);
      end else if (busy_q) begin
        ctr_q <= ctr_q - CTR_W'(1);
        if (ctr_q == CTR_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_abs;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NUM_WIDTH-1];
    end else if (busy_q) begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(~q_q + NUM_WIDTH'(1)) : $signed(q_q);

endmodule

`default_nettype wire

// ===== rtl/ggba_lane.sv =====
// One axis lane: bias register, window check, bias * count product and the
// serial divider that forms the running mean.
// Depends on ggba_pkg and ggba_div.
`default_nettype none

module ggba_lane #(
  parameter int unsigned COUNT_WIDTH = ggba_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire ggba_pkg::ggba_ctrl_t                   ctrl_i,
  input  wire logic signed [ggba_pkg::RATE_W-1:0]     sample_i,
  input  wire logic        [ggba_pkg::WIN_W-1:0]      win_i,
  input  wire logic        [COUNT_WIDTH-1:0]          count_i,
  output logic                                        inside_o,
  output logic                                        done_o,
  output logic signed      [ggba_pkg::BIAS_W-1:0]     bias_o,
  output logic signed      [ggba_pkg::CORR_W-1:0]     corrected_o
);

  localparam int unsigned BW   = ggba_pkg::BIAS_W;
  localparam int unsigned PW   = BW + COUNT_WIDTH + 1;  // bias * count
  localparam int unsigned NW   = PW + 1;                // plus the sample
  localparam int unsigned DW   = COUNT_WIDTH + 1;       // count + 1
  localparam int unsigned DEVW = BW + 2;

  logic signed [BW-1:0]   bias_q;
  logic signed [BW-1:0]   sx;
  logic signed [BW-1:0]   sx_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic signed [PW-1:0]   prod_d, prod_q;
  logic signed [NW-1:0]   num;
  logic [DW-1:0]          den;
  logic signed [NW-1:0]   quot;
  logic signed [BW-1:0]   bias_new;
  logic signed [DEVW-1:0] dev, win_pos, win_neg;

  // Rate in Q16.16
  assign sx = {sample_i, 8'b0};

  // Deviation from the current bias against the open window (-win, +win)
  always_comb begin
    dev      = {{2{sx[BW-1]}}, sx} - {{2{bias_q[BW-1]}}, bias_q};
    win_pos  = $signed({{(DEVW-ggba_pkg::WIN_W){1'b0}}, win_i});
    win_neg  = -win_pos;
    inside_o = (dev < win_pos) && (dev > win_neg);
  end

  assign prod_d = $signed(bias_q) * $signed({1'b0, count_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      sx_q   <= sx;
      cnt_q  <= count_i;
      prod_q <= prod_d;
    end
  end

  assign num = {prod_q[PW-1], prod_q} + {{(NW-BW){sx_q[BW-1]}}, sx_q};
  assign den = {1'b0, cnt_q} + DW'(1);

  ggba_div #(
    .NUM_WIDTH (NW),
    .DEN_WIDTH (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.div_go),
    .num_i   (num),
    .den_i   (den),
    .done_o  (done_o),
    .quot_o  (quot)
  );

  // The mean of in-range values stays in range: keep the low bits
  assign bias_new    = ctrl_i.acc ? $signed(quot[BW-1:0]) : bias_q;
  assign bias_o      = bias_new;
  assign corrected_o = {sx_q[BW-1], sx_q} - {bias_new[BW-1], bias_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
    end else if (ctrl_i.commit) begin
      bias_q <= bias_new;
    end
  end

endmodule

`default_nettype wire
